// ===== sv/div_tima_interval_timer_assert.svh =====
// assertion macros shared by the timer checker
`ifndef DIV_TIMA_INTERVAL_TIMER_ASSERT_SVH
`define DIV_TIMA_INTERVAL_TIMER_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define DTIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// next-cycle implication, checked on every clock outside reset
`define DTIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

// ===== sv/div_tima_pkg.sv =====
// shared types, codes and helpers of the interval timer
package div_tima_pkg;

    localparam int DIV_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int TAC_W   = 3;
    localparam int CMD_W   = 2;
    localparam int SEL_W   = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // register selects
    localparam logic [SEL_W-1:0] REG_DIV  = 2'd0;
    localparam logic [SEL_W-1:0] REG_TIMA = 2'd1;
    localparam logic [SEL_W-1:0] REG_TMA  = 2'd2;
    localparam logic [SEL_W-1:0] REG_TAC  = 2'd3;

    localparam int TAC_EN_BIT = 2;

    typedef logic [BYTE_W-1:0] t_byte;

    // controller to datapath
    typedef struct packed {
        logic start;     // item accepted this cycle
        logic step;      // advance the divider by one count
        logic load_out;  // move the finished result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic run_tick;  // accepted item is an enabled tick with a nonzero count
        logic last_step; // the current step is the final one
    } t_dp_sts;

    // divider bit watched for falling edges, per tac select
    function automatic logic [DIV_W-1:0] edge_mask(input logic [1:0] sel);
        logic [DIV_W-1:0] m;
        m = '0;
        unique case (sel)
            2'd0: m[9] = 1'b1;
            2'd1: m[3] = 1'b1;
            2'd2: m[5] = 1'b1;
            2'd3: m[7] = 1'b1;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/div_tima_ctrl.sv =====
// sequencing controller of the interval timer
module div_tima_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  div_tima_pkg::t_dp_sts i_sts,
    output div_tima_pkg::t_dp_cmd o_cmd
);
    import div_tima_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       load_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    // result moves on when the output register is empty or being drained
    assign load_out    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.start    = accept;
        o_cmd.step     = (r_state == S_STEP);
        o_cmd.load_out = load_out;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.run_tick ? S_STEP : S_DONE;
                end
            end
            S_STEP: begin
                if (i_sts.last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/div_tima_dp.sv =====
// timer registers, divider stepping and result register
module div_tima_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_command,
    input  logic [1:0]            i_reg_select,
    input  div_tima_pkg::t_byte   i_write_data,
    input  div_tima_pkg::t_byte   i_cycles,
    input  div_tima_pkg::t_dp_cmd i_cmd,
    output div_tima_pkg::t_dp_sts o_sts,
    output div_tima_pkg::t_byte   o_read_data,
    output logic                  o_timer_irq
);
    import div_tima_pkg::*;

    logic [DIV_W-1:0] r_divider, n_divider;
    t_byte            r_tima, n_tima;
    t_byte            r_tma, n_tma;
    logic [TAC_W-1:0] r_tac, n_tac;
    logic             r_pending, n_pending;
    t_byte            r_count, n_count;
    t_byte            r_rd, n_rd;
    logic             r_irq, n_irq;
    t_byte            r_out_rd;
    logic             r_out_irq;

    logic [DIV_W-1:0] div_inc;
    logic [DIV_W-1:0] mask;
    logic             fall;
    logic             tac_en;
    t_byte            rd_mux;

    assign tac_en  = r_tac[TAC_EN_BIT];
    assign div_inc = r_divider + DIV_W'(1);
    assign mask    = edge_mask(r_tac[1:0]);
    assign fall    = (|(r_divider & mask)) && !(|(div_inc & mask));

    assign o_sts.run_tick  = (i_command == CMD_TICK) && tac_en && (i_cycles != '0);
    assign o_sts.last_step = (r_count == t_byte'(1));

    always_comb begin
        unique case (i_reg_select)
            REG_DIV:  rd_mux = r_divider[DIV_W-1 -: BYTE_W];
            REG_TIMA: rd_mux = r_tima;
            REG_TMA:  rd_mux = r_tma;
            REG_TAC:  rd_mux = {{(BYTE_W-TAC_W){1'b0}}, r_tac};
            default:  rd_mux = '0;
        endcase
    end

    always_comb begin
        n_divider = r_divider;
        n_tima    = r_tima;
        n_tma     = r_tma;
        n_tac     = r_tac;
        n_pending = r_pending;
        n_count   = r_count;
        n_rd      = r_rd;
        n_irq     = r_irq;
        if (i_cmd.start) begin
            n_rd    = '0;
            n_irq   = 1'b0;
            n_count = i_cycles;
            // the unused command value falls through with zero results
            if (i_command == CMD_TICK) begin
                if (!tac_en) begin
                    n_divider = r_divider + {{(DIV_W-BYTE_W){1'b0}}, i_cycles};
                end else if (r_pending) begin
                    // reload from tma happens before any counting of this item
                    n_pending = 1'b0;
                    n_tima    = r_tma;
                    n_irq     = 1'b1;
                end
            end else if (i_command == CMD_READ) begin
                n_rd = rd_mux;
            end else if (i_command == CMD_WRITE) begin
                unique case (i_reg_select)
                    REG_DIV:  n_divider = '0;
                    REG_TIMA: n_tima    = i_write_data;
                    REG_TMA:  n_tma     = i_write_data;
                    REG_TAC:  n_tac     = i_write_data[TAC_W-1:0];
                    default:  n_tac     = r_tac;
                endcase
            end
        end else if (i_cmd.step) begin
            n_divider = div_inc;
            n_count   = r_count - t_byte'(1);
            if (fall) begin
                if (r_tima == '1) begin
                    n_pending = 1'b1;
                    n_tima    = '0;
                end else begin
                    n_tima = r_tima + t_byte'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= '0;
            r_tima    <= '0;
            r_tma     <= '0;
            r_tac     <= '0;
            r_pending <= 1'b0;
        end else begin
            r_divider <= n_divider;
            r_tima    <= n_tima;
            r_tma     <= n_tma;
            r_tac     <= n_tac;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_rd    <= n_rd;
        r_irq   <= n_irq;
        if (i_cmd.load_out) begin
            r_out_rd  <= r_rd;
            r_out_irq <= r_irq;
        end
    end

    assign o_read_data = r_out_rd;
    assign o_timer_irq = r_out_irq;

endmodule

// ===== sv/div_tima_interval_timer.sv =====
// Interval timer: 16-bit divider with DIV/TIMA/TMA/TAC registers behind one item channel.
// Input channel: i_in_valid / o_in_stall with i_command, i_reg_select, i_write_data,
// i_cycles; an item is taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_read_data, o_timer_irq; exactly one
// result per item, in order.
// Reads, writes, unused commands, disabled and zero-count ticks go straight to the done state.
// An enabled tick with i_cycles equal to N steps N times: the divider advances one count per
// clock through the single increment and edge-detect step.
// One item is in work at a time; the next item is taken in the cycle after its result
// enters the output register, even while that result is still held by i_out_stall.
// While i_out_stall holds a finished result and another item has completed, o_in_stall
// stays high until the output register is drained.
// Reset (i_rst_n low, synchronous) clears the divider, TIMA, TMA, TAC, the pending
// overflow and the output valid.
module div_tima_interval_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic [1:0]          i_reg_select,
    input  div_tima_pkg::t_byte i_write_data,
    input  div_tima_pkg::t_byte i_cycles,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output div_tima_pkg::t_byte o_read_data,
    output logic                o_timer_irq
);
    import div_tima_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    div_tima_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    div_tima_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_command    (i_command),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_cycles     (i_cycles),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_read_data  (o_read_data),
        .o_timer_irq  (o_timer_irq)
    );

endmodule

// ===== sv/div_tima_chk.sv =====
// port-level checker for the interval timer, bound to the top level
`include "div_tima_interval_timer_assert.svh"

module div_tima_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input div_tima_pkg::t_byte o_read_data,
    input logic                o_timer_irq
);
    import div_tima_pkg::*;

    // a result waiting on a stalled receiver stays offered
    `DTIT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    // one item in work at a time
    `DTIT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // an interrupt result never carries read data
    `DTIT_ASSERT_NOW(a_irq_no_data, i_clk, i_rst_n, o_out_valid && o_timer_irq, o_read_data == '0)
    // a new result only appears while an item was in work
    `DTIT_ASSERT_NOW(a_result_from_item, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind div_tima_interval_timer div_tima_chk u_chk (.*);
